// ===== rtl/deq_pkg.sv =====
// ----------------------------------------------------------------------------
// deq_pkg
// Shared types and codes for the double-ended queue core: command and status
// codes, field widths and the controller-to-datapath command group.
// ----------------------------------------------------------------------------
package deq_pkg;

	localparam int CMD_W    = 2;
	localparam int STATUS_W = 2;
	localparam int VALUE_W  = 32;
	localparam int OCC_W    = 4;

	typedef enum logic [CMD_W-1:0] {
		CMD_INS_REAR  = 2'd0,
		CMD_INS_FRONT = 2'd1,
		CMD_REM_FRONT = 2'd2,
		CMD_REM_REAR  = 2'd3
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_DONE  = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	// controller to datapath
	typedef struct packed {
		logic load;   // capture the incoming command word
		logic exec;   // carry out the captured command
	} deq_ctl_t;

endpackage

// ===== rtl/deq_ctrl.sv =====
// ----------------------------------------------------------------------------
// deq_ctrl
// Sequencer for the queue core: accepts a command, runs it through the execute
// state of the datapath and strobes the result for one cycle.
// ----------------------------------------------------------------------------
module deq_ctrl
	import deq_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	output logic     busy,
	output logic     done,
	output deq_ctl_t ctl
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_RESP
	} state_t;

	state_t state_q;
	logic   busy_q;
	logic   done_q;
	logic   accept;

	assign accept   = start && !busy_q;
	assign ctl.load = accept;
	assign ctl.exec = (state_q == S_EXEC);
	assign busy     = busy_q;
	assign done     = done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					done_q <= 1'b0;
					if (accept) begin
						state_q <= S_EXEC;
						busy_q  <= 1'b1;
					end
				end
				S_EXEC: begin
					state_q <= S_RESP;
					busy_q  <= 1'b0;
					done_q  <= 1'b1;
				end
				S_RESP: begin
					// next word may be taken while the result is on the ports
					done_q <= 1'b0;
					if (accept) begin
						state_q <= S_EXEC;
						busy_q  <= 1'b1;
					end else begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
					busy_q  <= 1'b0;
					done_q  <= 1'b0;
				end
			endcase
		end
	end

	a_accept_to_done: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##2 done)
		else $error("accepted word did not produce a result two cycles later");

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe held longer than one cycle");

	a_exec_busy: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.exec |-> busy)
		else $error("execute cycle while not busy");

endmodule

// ===== rtl/deq_datapath.sv =====
// ----------------------------------------------------------------------------
// deq_datapath
// Circular word store with head and tail pointers and a fill count. Executes
// one captured command per exec pulse and holds the result registers.
// ----------------------------------------------------------------------------
module deq_datapath
	import deq_pkg::*;
#(
	parameter int DEPTH      = 8,
	parameter int DATA_WIDTH = 32
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  deq_ctl_t                  ctl,
	input  logic [CMD_W-1:0]          command,
	input  logic signed [VALUE_W-1:0] data_value,
	output logic [STATUS_W-1:0]       status,
	output logic signed [VALUE_W-1:0] removed_value,
	output logic [OCC_W-1:0]          occupancy
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	logic [DATA_WIDTH-1:0] mem [DEPTH];

	cmd_t                  cmd_q;
	logic [DATA_WIDTH-1:0] data_q;
	logic [PTR_W-1:0]      head_q, tail_q;
	logic [CNT_W-1:0]      count_q;
	status_t               status_q;
	logic                  take_q;
	logic [DATA_WIDTH-1:0] rd_q;

	logic [PTR_W-1:0] head_inc, head_dec, tail_inc, tail_dec;
	logic [PTR_W-1:0] head_d, tail_d, wr_addr, rd_addr;
	logic [CNT_W-1:0] count_d;
	status_t          status_d;
	logic             take_d, wr_en, empty, full;

	assign empty = (count_q == '0);
	assign full  = (count_q == FULL_CNT);

	assign head_inc = (head_q == LAST) ? '0 : head_q + 1'b1;
	assign head_dec = (head_q == '0) ? LAST : head_q - 1'b1;
	assign tail_inc = (tail_q == LAST) ? '0 : tail_q + 1'b1;
	assign tail_dec = (tail_q == '0) ? LAST : tail_q - 1'b1;

	always_comb begin
		head_d   = head_q;
		tail_d   = tail_q;
		count_d  = count_q;
		status_d = ST_DONE;
		take_d   = 1'b0;
		wr_en    = 1'b0;
		wr_addr  = tail_inc;
		rd_addr  = head_q;
		case (cmd_q)
			CMD_INS_REAR, CMD_INS_FRONT: begin
				if (empty) begin
					// first word always lands at entry zero
					head_d  = '0;
					tail_d  = '0;
					wr_addr = '0;
					wr_en   = 1'b1;
					count_d = CNT_W'(1);
				end else if (full) begin
					status_d = ST_FULL;
				end else if (cmd_q == CMD_INS_REAR) begin
					tail_d  = tail_inc;
					wr_addr = tail_inc;
					wr_en   = 1'b1;
					count_d = count_q + 1'b1;
				end else begin
					head_d  = head_dec;
					wr_addr = head_dec;
					wr_en   = 1'b1;
					count_d = count_q + 1'b1;
				end
			end
			CMD_REM_FRONT, CMD_REM_REAR: begin
				rd_addr = (cmd_q == CMD_REM_FRONT) ? head_q : tail_q;
				if (empty) begin
					status_d = ST_EMPTY;
				end else begin
					take_d  = 1'b1;
					count_d = count_q - 1'b1;
					if (count_q == CNT_W'(1)) begin
						// last word out: park both pointers at zero
						head_d = '0;
						tail_d = '0;
					end else if (cmd_q == CMD_REM_FRONT) begin
						head_d = head_inc;
					end else begin
						tail_d = tail_dec;
					end
				end
			end
			default: begin
				status_d = ST_DONE;
			end
		endcase
	end

	// captured command word, payload only
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			cmd_q  <= cmd_t'(command);
			data_q <= DATA_WIDTH'($unsigned(data_value));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q   <= '0;
			tail_q   <= '0;
			count_q  <= '0;
			status_q <= ST_DONE;
			take_q   <= 1'b0;
		end else if (ctl.exec) begin
			head_q   <= head_d;
			tail_q   <= tail_d;
			count_q  <= count_d;
			status_q <= status_d;
			take_q   <= take_d;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.exec && wr_en) begin
			mem[wr_addr] <= data_q;
		end
		if (ctl.exec) begin
			rd_q <= mem[rd_addr];
		end
	end

	assign status        = status_q;
	assign removed_value = $signed(take_q ? VALUE_W'(rd_q) : {VALUE_W{1'b0}});
	assign occupancy     = OCC_W'(count_q);

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FULL_CNT)
		else $error("fill count beyond store depth");

	a_full_refuse: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.exec && full && (cmd_q == CMD_INS_REAR || cmd_q == CMD_INS_FRONT))
		|=> ($stable(count_q) && $stable(head_q) && $stable(tail_q)
			&& status_q == ST_FULL))
		else $error("insert into full queue changed state");

	a_single_ptrs: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == CNT_W'(1)) |-> (head_q == tail_q))
		else $error("one stored word but head and tail differ");

	a_ptr_range: assert property (@(posedge clk) disable iff (!arst_n)
		(head_q <= LAST) && (tail_q <= LAST))
		else $error("pointer outside store");

endmodule

// ===== rtl/double_ended_queue_core.sv =====
// ----------------------------------------------------------------------------
// double_ended_queue_core
// Double-ended queue over a circular store of DEPTH words with insert and
// remove at both ends, one status result per command.
// ----------------------------------------------------------------------------
// Result strobe (done) is raised in the result state, after the execute state
//   that follows acceptance. busy is high in the execute state, so no command
//   is taken there; the next command may be taken during the result state.
// The receiver cannot stall: done is high for one cycle per result.
// Reset clears pointers, fill count and control; store contents are left
//   undefined; removed_value is forced to zero unless a word was taken.
module double_ended_queue_core
	import deq_pkg::*;
#(
	parameter int DEPTH      = 8,
	parameter int DATA_WIDTH = 32
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  logic [CMD_W-1:0]          command,
	input  logic signed [VALUE_W-1:0] data_value,
	output logic                      done,
	output logic [STATUS_W-1:0]       status,
	output logic signed [VALUE_W-1:0] removed_value,
	output logic [OCC_W-1:0]          occupancy
);

	deq_ctl_t ctl;

	deq_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.ctl    (ctl)
	);

	deq_datapath #(
		.DEPTH      (DEPTH),
		.DATA_WIDTH (DATA_WIDTH)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctl           (ctl),
		.command       (command),
		.data_value    (data_value),
		.status        (status),
		.removed_value (removed_value),
		.occupancy     (occupancy)
	);

endmodule
